// File: sv/dfr_pkg.sv
// shared types and codes for the checksummed frame deframer
package dfr_pkg;

  // opcodes of an input word
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_PULL  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // result status codes
  localparam logic [2:0] ST_ACCEPTED  = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_INCOMPLETE = 3'd2;
  localparam logic [2:0] ST_FRAME_OK  = 3'd3;
  localparam logic [2:0] ST_BAD_SUM   = 3'd4;
  localparam logic [2:0] ST_OVERSIZE  = 3'd5;
  localparam logic [2:0] ST_CLEARED   = 3'd6;

  // frame bytes besides the payload: type, length, checksum
  localparam int unsigned FRAME_OVERHEAD = 3;

  // read address selection for the buffer memory
  localparam logic [1:0] RD_SAME = 2'd0;
  localparam logic [1:0] RD_HEAD = 2'd1;
  localparam logic [1:0] RD_NEXT = 2'd2;
  localparam logic [1:0] RD_PAY  = 2'd3;

  // what the output register carries besides status
  localparam logic [1:0] KIND_ZERO = 2'd0;
  localparam logic [1:0] KIND_TYPE = 2'd1;
  localparam logic [1:0] KIND_PAY  = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic [1:0] rd_sel;
    logic       push_wr;
    logic       clear;
    logic       drop_one;
    logic       drop_frame;
    logic       lat_type;
    logic       lat_len;
    logic       add_sum;
    logic       idx_clr;
    logic       idx_inc;
    logic       out_ld;
    logic [2:0] out_status;
    logic [1:0] out_kind;
  } dfr_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic full;
    logic fill_lt3;
    logic oversize;
    logic incomplete;
    logic idx_at_len;
    logic idx_last;
    logic sum_ok;
    logic len_zero;
    logic out_free;
  } dfr_sts_t;

endpackage

// File: sv/checksummed_frame_deframer.sv
// top level of the checksummed frame deframer
//
// Input words carry an opcode and a received byte: push stores the byte in a
// ring buffer of BUF_DEPTH bytes, pull makes one attempt to take a frame
// (type, length, payload, checksum) off the front, clear empties the buffer.
// Each input gives one result word, or one per payload byte for a good frame,
// with last set on the final one. An unused opcode is taken and gives none.
// Both channels hand over a word when valid is high and stall is low.
// Push and clear: the result is in the output register in the next cycle.
// Pull: with fewer than three bytes held the result is loaded at once; else the
// type and length bytes are read for the oversize and incomplete checks, and a
// frame is summed and checked; a good one gives one payload result per cycle while the
// receiver does not stall: the single read port of the buffer memory walks it twice.
// One input is in work at a time.
// A stalled receiver holds the output register; the walk waits in place.
// Reset empties the buffer (head and fill to zero) and drops any pending
// result; the memory itself needs no clearing.
module checksummed_frame_deframer #(
  parameter int BUF_DEPTH   = 128,
  parameter int MAX_PAYLOAD = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_opcode,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_status,
  output logic [7:0] out_frame_type,
  output logic [6:0] out_frame_length,
  output logic [7:0] out_payload_byte,
  output logic [5:0] out_byte_index,
  output logic       out_last
);

  dfr_pkg::dfr_cmd_t cmd;
  dfr_pkg::dfr_sts_t sts;

  // sequencer
  dfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_opcode),
    .sts       (sts),
    .cmd       (cmd)
  );

  // buffer and output datapath
  dfr_dp #(
    .BUF_DEPTH   (BUF_DEPTH),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_rx_byte       (in_rx_byte),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_frame_type   (out_frame_type),
    .out_frame_length (out_frame_length),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_last         (out_last)
  );

`ifndef SYNTHESIS
  // a result is only loaded into a free output slot
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> sts.out_free)
    else $error("output word loaded over a pending result");

  // an accepted input word always has room for its first result
  a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> sts.out_free)
    else $error("input word accepted without a free output slot");

  // a push never coincides with removal from the buffer
  a_push_alone: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_wr |-> !(cmd.drop_one || cmd.drop_frame || cmd.clear))
    else $error("push overlaps a buffer removal");

  // after a clear the buffer holds too few bytes for a frame
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> sts.fill_lt3)
    else $error("buffer not empty after clear");
`endif

endmodule

// File: sv/dfr_ctrl.sv
// controller state machine: sequences push, clear and frame pulls
module dfr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_opcode,
  input  dfr_pkg::dfr_sts_t sts,
  output dfr_pkg::dfr_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TYPE = 3'd1;
  localparam logic [2:0] S_LEN  = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // next state and commands
  always_comb begin
    cmd            = '0;
    cmd.rd_sel     = dfr_pkg::RD_SAME;
    cmd.out_kind   = dfr_pkg::KIND_ZERO;
    cmd.out_status = dfr_pkg::ST_ACCEPTED;
    state_nxt      = state_r;
    in_stall       = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = !sts.out_free;
        if (in_valid && sts.out_free) begin
          unique case (in_opcode)
            dfr_pkg::OP_PUSH: begin
              cmd.out_ld     = 1'b1;
              cmd.push_wr    = !sts.full;
              cmd.out_status = sts.full ? dfr_pkg::ST_FULL : dfr_pkg::ST_ACCEPTED;
            end
            dfr_pkg::OP_CLEAR: begin
              cmd.clear      = 1'b1;
              cmd.out_ld     = 1'b1;
              cmd.out_status = dfr_pkg::ST_CLEARED;
            end
            dfr_pkg::OP_PULL: begin
              if (sts.fill_lt3) begin
                cmd.out_ld     = 1'b1;
                cmd.out_status = dfr_pkg::ST_INCOMPLETE;
              end else begin
                cmd.rd_sel = dfr_pkg::RD_HEAD;
                state_nxt  = S_TYPE;
              end
            end
            default: begin
              // unused opcode: taken, no result
            end
          endcase
        end
      end
      // type byte arrives, fetch length
      S_TYPE: begin
        cmd.lat_type = 1'b1;
        cmd.rd_sel   = dfr_pkg::RD_NEXT;
        state_nxt    = S_LEN;
      end
      // length byte arrives: size checks
      S_LEN: begin
        if (sts.oversize || sts.incomplete) begin
          if (sts.out_free) begin
            cmd.out_ld     = 1'b1;
            cmd.drop_one   = sts.oversize;
            cmd.out_status = sts.oversize ? dfr_pkg::ST_OVERSIZE : dfr_pkg::ST_INCOMPLETE;
            state_nxt      = S_IDLE;
          end
        end else begin
          cmd.lat_len = 1'b1;
          cmd.idx_clr = 1'b1;
          cmd.rd_sel  = dfr_pkg::RD_NEXT;
          state_nxt   = S_SUM;
        end
      end
      // walk the payload into the sum, then check the checksum byte
      S_SUM: begin
        if (!sts.idx_at_len) begin
          cmd.add_sum = 1'b1;
          cmd.idx_inc = 1'b1;
          cmd.rd_sel  = dfr_pkg::RD_NEXT;
        end else if (sts.out_free) begin
          priority if (!sts.sum_ok) begin
            cmd.out_ld     = 1'b1;
            cmd.drop_one   = 1'b1;
            cmd.out_status = dfr_pkg::ST_BAD_SUM;
            state_nxt      = S_IDLE;
          end else if (sts.len_zero) begin
            cmd.out_ld     = 1'b1;
            cmd.drop_frame = 1'b1;
            cmd.out_status = dfr_pkg::ST_FRAME_OK;
            cmd.out_kind   = dfr_pkg::KIND_TYPE;
            state_nxt      = S_IDLE;
          end else begin
            cmd.rd_sel  = dfr_pkg::RD_PAY;
            cmd.idx_clr = 1'b1;
            state_nxt   = S_EMIT;
          end
        end
      end
      // second walk: one payload word per free output slot
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_ld     = 1'b1;
          cmd.out_status = dfr_pkg::ST_FRAME_OK;
          cmd.out_kind   = dfr_pkg::KIND_PAY;
          if (sts.idx_last) begin
            cmd.drop_frame = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            cmd.rd_sel  = dfr_pkg::RD_NEXT;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: sv/dfr_dp.sv
// datapath: ring buffer memory, pointers, checksum sum and output register
module dfr_dp #(
  parameter int BUF_DEPTH   = 128,
  parameter int MAX_PAYLOAD = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_rx_byte,
  input  dfr_pkg::dfr_cmd_t cmd,
  output dfr_pkg::dfr_sts_t sts,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_status,
  output logic [7:0]        out_frame_type,
  output logic [6:0]        out_frame_length,
  output logic [7:0]        out_payload_byte,
  output logic [5:0]        out_byte_index,
  output logic              out_last
);

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int CW = $clog2(BUF_DEPTH + 1);
  localparam int XW = (CW > 7) ? CW : 7;

  logic [7:0]    mem_r [BUF_DEPTH];
  logic [AW-1:0] head_r;
  logic [AW-1:0] head_nxt;
  logic [CW-1:0] fill_r;
  logic [CW-1:0] fill_nxt;
  logic [AW-1:0] rd_ptr_r;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [7:0]    rd_data_r;
  logic [7:0]    type_r;
  logic [6:0]    len_r;
  logic [7:0]    sum_r;
  logic [6:0]    idx_r;
  logic [6:0]    rd_tot;
  logic [6:0]    len_tot;
  logic [XW-1:0] rd_tot_x;
  logic [XW-1:0] fill_x;
  logic [7:0]    chk;
  logic          out_valid_r;
  logic [2:0]    out_status_r;
  logic [7:0]    out_type_r;
  logic [6:0]    out_len_r;
  logic [7:0]    out_pay_r;
  logic [5:0]    out_idx_r;
  logic          out_last_r;

  // ring index add, sum is always below twice the depth
  function automatic logic [AW-1:0] wrap_add(input logic [AW:0] s);
    logic [AW:0] depth_w;
    depth_w = (AW + 1)'(BUF_DEPTH);
    if (s >= depth_w) begin
      return AW'(s - depth_w);
    end
    return s[AW-1:0];
  endfunction

  // read and write addresses
  always_comb begin
    unique case (cmd.rd_sel)
      dfr_pkg::RD_HEAD: rd_addr = head_r;
      dfr_pkg::RD_NEXT: rd_addr = wrap_add((AW + 1)'(rd_ptr_r) + (AW + 1)'(1));
      dfr_pkg::RD_PAY:  rd_addr = wrap_add((AW + 1)'(head_r) + (AW + 1)'(2));
      default:          rd_addr = rd_ptr_r;
    endcase
    wr_addr = wrap_add((AW + 1)'(head_r) + (AW + 1)'(fill_r));
  end

  // buffer memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.push_wr) begin
      mem_r[wr_addr] <= in_rx_byte;
    end
    rd_data_r <= mem_r[rd_addr];
    rd_ptr_r  <= rd_addr;
  end

  // frame sizes from the length byte being read and from the latched one
  always_comb begin
    rd_tot   = rd_data_r[6:0] + 7'(dfr_pkg::FRAME_OVERHEAD);
    len_tot  = len_r + 7'(dfr_pkg::FRAME_OVERHEAD);
    rd_tot_x = XW'(rd_tot);
    fill_x   = XW'(fill_r);
    chk      = sum_r + rd_data_r;
  end

  // head and fill updates
  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    priority if (cmd.clear) begin
      head_nxt = '0;
      fill_nxt = '0;
    end else if (cmd.push_wr) begin
      fill_nxt = fill_r + CW'(1);
    end else if (cmd.drop_one) begin
      head_nxt = wrap_add((AW + 1)'(head_r) + (AW + 1)'(1));
      fill_nxt = fill_r - CW'(1);
    end else if (cmd.drop_frame) begin
      head_nxt = wrap_add((AW + 1)'(head_r) + (AW + 1)'(len_tot));
      fill_nxt = fill_r - CW'(len_tot);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
    end
  end

  // frame header, running sum and byte index
  always_ff @(posedge clk) begin
    if (cmd.lat_type) begin
      type_r <= rd_data_r;
    end
    if (cmd.lat_len) begin
      len_r <= rd_data_r[6:0];
      sum_r <= type_r + rd_data_r;
    end else if (cmd.add_sum) begin
      sum_r <= sum_r + rd_data_r;
    end
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + 7'd1;
    end
  end

  // status towards the controller
  always_comb begin
    sts.full       = (fill_r == CW'(BUF_DEPTH));
    sts.fill_lt3   = (fill_r < CW'(dfr_pkg::FRAME_OVERHEAD));
    sts.oversize   = (rd_data_r > 8'(MAX_PAYLOAD)) || (rd_tot_x > XW'(BUF_DEPTH));
    sts.incomplete = (fill_x < rd_tot_x);
    sts.idx_at_len = (idx_r == len_r);
    sts.idx_last   = ((idx_r + 7'd1) == len_r);
    sts.sum_ok     = (chk == 8'd0);
    sts.len_zero   = (len_r == 7'd0);
    sts.out_free   = !out_valid_r || !out_stall;
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_status_r <= cmd.out_status;
      out_type_r   <= (cmd.out_kind != dfr_pkg::KIND_ZERO) ? type_r : 8'd0;
      out_len_r    <= (cmd.out_kind == dfr_pkg::KIND_PAY) ? len_r : 7'd0;
      out_pay_r    <= (cmd.out_kind == dfr_pkg::KIND_PAY) ? rd_data_r : 8'd0;
      out_idx_r    <= (cmd.out_kind == dfr_pkg::KIND_PAY) ? idx_r[5:0] : 6'd0;
      out_last_r   <= (cmd.out_kind == dfr_pkg::KIND_PAY) ? sts.idx_last : 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_frame_type   = out_type_r;
  assign out_frame_length = out_len_r;
  assign out_payload_byte = out_pay_r;
  assign out_byte_index   = out_idx_r;
  assign out_last         = out_last_r;

endmodule

// File: test/tb_checksummed_frame_deframer.sv
// testbench for the checksummed frame deframer: directed and random words, self-checking
`timescale 1ns / 100ps

module tb_checksummed_frame_deframer;

  localparam int BUF_DEPTH    = 128;
  localparam int MAX_PAYLOAD  = 64;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 200;
  localparam int REFILL_MARK  = 96;

  // opcode the block takes without answering
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    logic [2:0] status;
    logic [7:0] frame_type;
    logic [6:0] frame_length;
    logic [7:0] payload_byte;
    logic [5:0] byte_index;
    logic       last;
  } frame_result_t;

  logic       clk;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic       in_stall;
  logic [1:0] in_opcode  = dfr_pkg::OP_PUSH;
  logic [7:0] in_rx_byte = 8'd0;
  logic       out_valid;
  logic       out_stall  = 1'b0;
  logic [2:0] out_status;
  logic [7:0] out_frame_type;
  logic [6:0] out_frame_length;
  logic [7:0] out_payload_byte;
  logic [5:0] out_byte_index;
  logic       out_last;

  // predictor state: receive ring and its fill
  logic [7:0]    ring_bytes[BUF_DEPTH];
  int            ring_head = 0;
  int            ring_fill = 0;
  frame_result_t pending_results[$];

  int fail_count    = 0;
  int sent_words    = 0;
  int idle_cycles   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  checksummed_frame_deframer #(
    .BUF_DEPTH  (BUF_DEPTH),
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_frame_type  (out_frame_type),
    .out_frame_length(out_frame_length),
    .out_payload_byte(out_payload_byte),
    .out_byte_index  (out_byte_index),
    .out_last        (out_last)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [7:0] ring_at(input int offset);
    return ring_bytes[(ring_head + offset) % BUF_DEPTH];
  endfunction

  task automatic drop_front(input int n);
    ring_head = (ring_head + n) % BUF_DEPTH;
    ring_fill = ring_fill - n;
  endtask

  task automatic expect_result(input logic [2:0] status, input logic [7:0] ftype,
                               input logic [6:0] flen, input logic [7:0] pay,
                               input logic [5:0] idx, input logic last);
    frame_result_t r;
    r.status       = status;
    r.frame_type   = ftype;
    r.frame_length = flen;
    r.payload_byte = pay;
    r.byte_index   = idx;
    r.last         = last;
    pending_results.push_back(r);
  endtask

  // work out the results of one accepted word and update the ring
  task automatic deframe_word(input logic [1:0] op, input logic [7:0] rx);
    logic [7:0] ftype;
    logic [7:0] flen;
    logic [7:0] acc;
    logic [7:0] want_sum;
    int         total;
    case (op)
      dfr_pkg::OP_PUSH: begin
        if (ring_fill >= BUF_DEPTH) begin
          expect_result(dfr_pkg::ST_FULL, 8'd0, 7'd0, 8'd0, 6'd0, 1'b1);
        end else begin
          ring_bytes[(ring_head + ring_fill) % BUF_DEPTH] = rx;
          ring_fill++;
          expect_result(dfr_pkg::ST_ACCEPTED, 8'd0, 7'd0, 8'd0, 6'd0, 1'b1);
        end
      end
      dfr_pkg::OP_CLEAR: begin
        ring_head = 0;
        ring_fill = 0;
        expect_result(dfr_pkg::ST_CLEARED, 8'd0, 7'd0, 8'd0, 6'd0, 1'b1);
      end
      dfr_pkg::OP_PULL: begin
        if (ring_fill < dfr_pkg::FRAME_OVERHEAD) begin
          expect_result(dfr_pkg::ST_INCOMPLETE, 8'd0, 7'd0, 8'd0, 6'd0, 1'b1);
        end else begin
          ftype = ring_at(0);
          flen  = ring_at(1);
          total = dfr_pkg::FRAME_OVERHEAD + flen;
          if (flen > MAX_PAYLOAD || total > BUF_DEPTH) begin
            drop_front(1);
            expect_result(dfr_pkg::ST_OVERSIZE, 8'd0, 7'd0, 8'd0, 6'd0, 1'b1);
          end else if (ring_fill < total) begin
            expect_result(dfr_pkg::ST_INCOMPLETE, 8'd0, 7'd0, 8'd0, 6'd0, 1'b1);
          end else begin
            // all frame bytes must sum to zero modulo 256
            acc = ftype + flen;
            for (int i = 0; i < flen; i++) acc = acc + ring_at(2 + i);
            want_sum = ~acc + 8'd1;
            if (want_sum != ring_at(2 + flen)) begin
              drop_front(1);
              expect_result(dfr_pkg::ST_BAD_SUM, 8'd0, 7'd0, 8'd0, 6'd0, 1'b1);
            end else if (flen == 0) begin
              drop_front(total);
              expect_result(dfr_pkg::ST_FRAME_OK, ftype, 7'd0, 8'd0, 6'd0, 1'b1);
            end else begin
              for (int i = 0; i < flen; i++)
                expect_result(dfr_pkg::ST_FRAME_OK, ftype, 7'(flen), ring_at(2 + i),
                              6'(i), i == flen - 1);
              drop_front(total);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // hand one word to the block, with random idle cycles before it
  task automatic send_word(input logic [1:0] op, input logic [7:0] rx);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_opcode  <= op;
    in_rx_byte <= rx;
    do @(posedge clk); while (in_stall);
    deframe_word(op, rx);
    if (op != OP_UNUSED) sent_words++;
  endtask

  function automatic byte_q_t random_payload(input int len);
    byte_q_t q;
    repeat (len) q.push_back(8'($urandom));
    return q;
  endfunction

  // push one frame byte by byte, optionally corrupted, with pulls mixed in
  task automatic push_frame(input logic [7:0] ftype, input byte_q_t pay, input bit bad_sum,
                            input bit oversize, input int pull_pct);
    byte_q_t    frame;
    logic [7:0] acc;
    logic [7:0] chk;
    acc = ftype + 8'(pay.size());
    foreach (pay[i]) acc = acc + pay[i];
    chk = ~acc + 8'd1;
    if (bad_sum) chk = chk ^ (8'd1 << $urandom_range(0, 7));
    frame.push_back(ftype);
    frame.push_back(oversize ? 8'($urandom_range(MAX_PAYLOAD + 1, 255)) : 8'(pay.size()));
    foreach (pay[i]) frame.push_back(pay[i]);
    frame.push_back(chk);
    foreach (frame[i]) begin
      send_word(dfr_pkg::OP_PUSH, frame[i]);
      if ($urandom_range(0, 99) < pull_pct) send_word(dfr_pkg::OP_PULL, 8'($urandom));
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // random receiver stalls
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // compare each result word with the oldest expectation
  always @(posedge clk) begin : check_results
    frame_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual status %0d",
                 $time, out_status);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, out_status);
        check_field("frame_type", want.frame_type, out_frame_type);
        check_field("frame_length", want.frame_length, out_frame_length);
        check_field("payload_byte", want.payload_byte, out_payload_byte);
        check_field("byte_index", want.byte_index, out_byte_index);
        check_field("last", want.last, out_last);
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("checksummed_frame_deframer test failed");
      $finish;
    end
  end

  // pull on an empty buffer and an unused opcode
  task automatic test_empty_and_unused();
    send_word(dfr_pkg::OP_PULL, 8'h00);
    send_word(OP_UNUSED, 8'hff);
  endtask

  // zero-length frame, then a frame pulled after every byte with extreme bytes
  task automatic test_small_frames();
    byte_q_t none;
    push_frame(8'h00, none, 1'b0, 1'b0, 0);
    send_word(dfr_pkg::OP_PULL, 8'hff);
    push_frame(8'hff, '{8'hff, 8'h00}, 1'b0, 1'b0, 100);
  endtask

  // bad checksum resync and oversize length drops
  task automatic test_bad_frames();
    push_frame(8'h5a, '{8'h11}, 1'b1, 1'b0, 0);
    send_word(dfr_pkg::OP_PULL, 8'h00);
    send_word(dfr_pkg::OP_PULL, 8'h00);
    send_word(dfr_pkg::OP_CLEAR, 8'h00);
    push_frame(8'h10, '{8'h80}, 1'b0, 1'b1, 0);
    repeat (3) send_word(dfr_pkg::OP_PULL, 8'h00);
    send_word(dfr_pkg::OP_CLEAR, 8'hff);
  endtask

  // fill the buffer exactly with two long frames, overflow it, then drain
  task automatic test_full_buffer();
    send_word(dfr_pkg::OP_CLEAR, 8'h00);
    push_frame(8'($urandom), random_payload(MAX_PAYLOAD), 1'b0, 1'b0, 0);
    push_frame(8'($urandom),
               random_payload(BUF_DEPTH - MAX_PAYLOAD - 2 * dfr_pkg::FRAME_OVERHEAD),
               1'b0, 1'b0, 0);
    send_word(dfr_pkg::OP_PUSH, 8'($urandom));
    repeat (3) send_word(dfr_pkg::OP_PULL, 8'($urandom));
  endtask

  // mostly well-formed frames, with corruption, noise, clears and stray pulls
  task automatic test_random_traffic(input int n_words);
    int      stop_at;
    int      pick;
    int      len;
    bit      bad_sum;
    bit      oversize;
    stop_at = sent_words + n_words;
    while (sent_words < stop_at) begin
      pick = $urandom_range(0, 99);
      if (ring_fill > REFILL_MARK) begin
        send_word(dfr_pkg::OP_CLEAR, 8'($urandom));
      end else if (pick < 70) begin
        pick = $urandom_range(0, 99);
        len = (pick < 70) ? $urandom_range(0, 6) :
              (pick < 95) ? $urandom_range(7, 24) : $urandom_range(25, MAX_PAYLOAD);
        pick     = $urandom_range(0, 99);
        bad_sum  = (pick < 10);
        oversize = (pick >= 10 && pick < 15);
        push_frame(8'($urandom), random_payload(len), bad_sum, oversize, 8);
        send_word(dfr_pkg::OP_PULL, 8'($urandom));
        if ((bad_sum || oversize) && $urandom_range(0, 1))
          send_word(dfr_pkg::OP_CLEAR, 8'($urandom));
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 4)) send_word(dfr_pkg::OP_PUSH, 8'($urandom));
        send_word(dfr_pkg::OP_PULL, 8'($urandom));
      end else if (pick < 85) begin
        send_word(dfr_pkg::OP_CLEAR, 8'($urandom));
      end else if (pick < 88) begin
        send_word(OP_UNUSED, 8'($urandom));
      end else begin
        send_word(dfr_pkg::OP_PULL, 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 19;
    recv_idle_pct = 47;
    test_empty_and_unused();
    test_small_frames();
    test_bad_frames();
    test_full_buffer();
    test_random_traffic(80);

    send_idle_pct = 47;
    recv_idle_pct = 19;
    test_random_traffic(80);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(80);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("checksummed_frame_deframer test passed");
    else
      $display("checksummed_frame_deframer test failed");
    $finish;
  end

endmodule
